FILE: src/lpp_pkg.sv
package lpp_pkg;

    // Dense kind codes reported on the result channel
    localparam logic [3:0] KIND_DIG_IN   = 4'd0;
    localparam logic [3:0] KIND_DIG_OUT  = 4'd1;
    localparam logic [3:0] KIND_AN_IN    = 4'd2;
    localparam logic [3:0] KIND_AN_OUT   = 4'd3;
    localparam logic [3:0] KIND_LUX      = 4'd4;
    localparam logic [3:0] KIND_PRESENCE = 4'd5;
    localparam logic [3:0] KIND_TEMP     = 4'd6;
    localparam logic [3:0] KIND_HUMIDITY = 4'd7;
    localparam logic [3:0] KIND_ACCEL    = 4'd8;
    localparam logic [3:0] KIND_BARO     = 4'd9;
    localparam logic [3:0] KIND_GYRO     = 4'd10;
    localparam logic [3:0] KIND_GPS      = 4'd11;

    // Type bytes on the wire
    localparam logic [7:0] TYPE_DIG_IN   = 8'd0;
    localparam logic [7:0] TYPE_DIG_OUT  = 8'd1;
    localparam logic [7:0] TYPE_AN_IN    = 8'd2;
    localparam logic [7:0] TYPE_AN_OUT   = 8'd3;
    localparam logic [7:0] TYPE_LUX      = 8'd101;
    localparam logic [7:0] TYPE_PRESENCE = 8'd102;
    localparam logic [7:0] TYPE_TEMP     = 8'd103;
    localparam logic [7:0] TYPE_HUMIDITY = 8'd104;
    localparam logic [7:0] TYPE_ACCEL    = 8'd113;
    localparam logic [7:0] TYPE_BARO     = 8'd115;
    localparam logic [7:0] TYPE_GYRO     = 8'd134;
    localparam logic [7:0] TYPE_GPS      = 8'd136;

    localparam int VALUE_W = 24;

    typedef enum logic [2:0] {
        PH_CHANNEL = 3'b001,
        PH_TYPE    = 3'b010,
        PH_DATA    = 3'b100
    } phase_t;

    typedef struct packed {
        logic                       record_valid;
        logic [7:0]                 channel;
        logic [3:0]                 kind;
        logic signed [VALUE_W-1:0]  value_a;
        logic signed [VALUE_W-1:0]  value_b;
        logic signed [VALUE_W-1:0]  value_c;
        logic                       frame_end;
        logic                       frame_ok;
    } result_t;

    typedef struct packed {
        logic       known;
        logic [3:0] kind;
    } kind_lookup_t;

    function automatic kind_lookup_t type_to_kind(input logic [7:0] type_byte);
        kind_lookup_t r;
        r.known = 1'b1;
        case (type_byte)
            TYPE_DIG_IN:   r.kind = KIND_DIG_IN;
            TYPE_DIG_OUT:  r.kind = KIND_DIG_OUT;
            TYPE_AN_IN:    r.kind = KIND_AN_IN;
            TYPE_AN_OUT:   r.kind = KIND_AN_OUT;
            TYPE_LUX:      r.kind = KIND_LUX;
            TYPE_PRESENCE: r.kind = KIND_PRESENCE;
            TYPE_TEMP:     r.kind = KIND_TEMP;
            TYPE_HUMIDITY: r.kind = KIND_HUMIDITY;
            TYPE_ACCEL:    r.kind = KIND_ACCEL;
            TYPE_BARO:     r.kind = KIND_BARO;
            TYPE_GYRO:     r.kind = KIND_GYRO;
            TYPE_GPS:      r.kind = KIND_GPS;
            default: begin
                r.known = 1'b0;
                r.kind  = KIND_DIG_IN;
            end
        endcase
        return r;
    endfunction

    // Data bytes per record
    function automatic logic [3:0] kind_len(input logic [3:0] kind);
        case (kind)
            KIND_DIG_IN, KIND_DIG_OUT, KIND_PRESENCE, KIND_HUMIDITY: kind_len = 4'd1;
            KIND_ACCEL, KIND_GYRO:                                   kind_len = 4'd6;
            KIND_GPS:                                                kind_len = 4'd9;
            default:                                                 kind_len = 4'd2;
        endcase
    endfunction

    // Bytes per value
    function automatic logic [1:0] kind_esz(input logic [3:0] kind);
        case (kind)
            KIND_DIG_IN, KIND_DIG_OUT, KIND_PRESENCE, KIND_HUMIDITY: kind_esz = 2'd1;
            KIND_GPS:                                                kind_esz = 2'd3;
            default:                                                 kind_esz = 2'd2;
        endcase
    endfunction

    function automatic logic kind_signed(input logic [3:0] kind);
        case (kind)
            KIND_AN_IN, KIND_AN_OUT, KIND_TEMP, KIND_ACCEL, KIND_GYRO, KIND_GPS:
                kind_signed = 1'b1;
            default:
                kind_signed = 1'b0;
        endcase
    endfunction

    // Which value a data byte belongs to, clamped to the third
    function automatic logic [1:0] elem_index(input logic [3:0] count, input logic [1:0] esz);
        logic [1:0] e;
        case (esz)
            2'd2: e = (count >= 4'd4) ? 2'd2 : count[2:1];
            2'd3: e = (count >= 4'd6) ? 2'd2 : ((count >= 4'd3) ? 2'd1 : 2'd0);
            default: e = (count >= 4'd2) ? 2'd2 : count[1:0];
        endcase
        return e;
    endfunction

    function automatic logic [VALUE_W-1:0] finish_value(input logic [VALUE_W-1:0] v,
                                                        input logic [1:0] esz,
                                                        input logic sgn);
        logic [VALUE_W-1:0] r;
        case (esz)
            2'd1: r = {16'd0, v[7:0]};
            2'd2: r = {{8{sgn & v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

FILE: src/lpp_parser.sv
module lpp_parser #(
    parameter int MAX_PAYLOAD_BYTES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_en,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                res_gen,
    output lpp_pkg::result_t    res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);

    lpp_pkg::phase_t                     phase_reg, phase_next;
    logic [7:0]                          channel_reg, channel_next;
    logic [3:0]                          kind_reg, kind_next;
    logic [3:0]                          pcount_reg, pcount_next;
    logic [lpp_pkg::VALUE_W-1:0]         shift_reg [3];
    logic [lpp_pkg::VALUE_W-1:0]         shift_next [3];
    logic [CNT_W-1:0]                    fcount_reg, fcount_next;
    logic                                good_reg, good_next;

    lpp_pkg::kind_lookup_t               lookup;
    logic [1:0]                          esz;
    logic [1:0]                          elem;
    logic                                sgn;
    logic                                rec;
    logic [lpp_pkg::VALUE_W-1:0]         va, vb, vc;

    assign lookup = lpp_pkg::type_to_kind(data_byte);
    assign esz    = lpp_pkg::kind_esz(kind_reg);
    assign sgn    = lpp_pkg::kind_signed(kind_reg);
    assign elem   = lpp_pkg::elem_index(pcount_reg, esz);

    always_comb begin
        phase_next   = phase_reg;
        channel_next = channel_reg;
        kind_next    = kind_reg;
        pcount_next  = pcount_reg;
        fcount_next  = fcount_reg;
        good_next    = good_reg;
        for (int i = 0; i < 3; i++) begin
            shift_next[i] = shift_reg[i];
        end
        rec = 1'b0;

        // drop bytes beyond capacity without parsing
        if (fcount_reg < CNT_W'(MAX_PAYLOAD_BYTES)) begin
            fcount_next = fcount_reg + CNT_W'(1);
            case (phase_reg)
                lpp_pkg::PH_CHANNEL: begin
                    channel_next = data_byte;
                    phase_next   = lpp_pkg::PH_TYPE;
                end
                lpp_pkg::PH_TYPE: begin
                    if (!lookup.known) begin
                        good_next  = 1'b0;
                        phase_next = lpp_pkg::PH_CHANNEL;
                    end else begin
                        kind_next   = lookup.kind;
                        pcount_next = 4'd0;
                        for (int i = 0; i < 3; i++) begin
                            shift_next[i] = '0;
                        end
                        phase_next = lpp_pkg::PH_DATA;
                    end
                end
                lpp_pkg::PH_DATA: begin
                    shift_next[elem] = {shift_reg[elem][15:0], data_byte};
                    pcount_next      = pcount_reg + 4'd1;
                    if (pcount_next >= lpp_pkg::kind_len(kind_reg)) begin
                        rec         = 1'b1;
                        pcount_next = 4'd0;
                        phase_next  = lpp_pkg::PH_CHANNEL;
                    end
                end
                default: begin
                    phase_next = lpp_pkg::PH_CHANNEL;
                end
            endcase
        end

        va = lpp_pkg::finish_value(shift_next[0], esz, sgn);
        vb = lpp_pkg::finish_value(shift_next[1], esz, sgn);
        vc = lpp_pkg::finish_value(shift_next[2], esz, sgn);
        if (lpp_pkg::kind_len(kind_reg) == {2'd0, esz}) begin
            vb = '0;
            vc = '0;
        end

        res_gen          = byte_en && (rec || last_byte);
        res.record_valid = rec;
        res.channel      = rec ? channel_reg : 8'd0;
        res.kind         = rec ? kind_reg : 4'd0;
        res.value_a      = rec ? va : '0;
        res.value_b      = rec ? vb : '0;
        res.value_c      = rec ? vc : '0;
        res.frame_end    = last_byte;
        res.frame_ok     = last_byte && good_next && (phase_next == lpp_pkg::PH_CHANNEL)
                           && (fcount_next >= CNT_W'(2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_en && last_byte)) begin
            phase_reg   <= lpp_pkg::PH_CHANNEL;
            channel_reg <= 8'd0;
            kind_reg    <= 4'd0;
            pcount_reg  <= 4'd0;
            fcount_reg  <= '0;
            good_reg    <= 1'b1;
            for (int i = 0; i < 3; i++) begin
                shift_reg[i] <= '0;
            end
        end else if (byte_en) begin
            phase_reg   <= phase_next;
            channel_reg <= channel_next;
            kind_reg    <= kind_next;
            pcount_reg  <= pcount_next;
            fcount_reg  <= fcount_next;
            good_reg    <= good_next;
            for (int i = 0; i < 3; i++) begin
                shift_reg[i] <= shift_next[i];
            end
        end
    end

endmodule

FILE: src/lpp_sensor_record_parser_core.sv
// A result enters the output register as its byte is taken, or the skid register on a stall.
// Throughput: one byte per cycle while s_tready is high; parse state updates once per byte.
// A two-entry output (result register plus skid register) keeps s_tready registered,
// so a stall on m_tready stops input only once the skid entry fills.
// Reset (aresetn low, synchronous) returns the parser to the channel byte, clears the
// frame byte count, sets the frame good flag and empties both output entries.
module lpp_sensor_record_parser_core #(
    parameter int MAX_PAYLOAD_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] channel, [31:8] value_a, [55:32] value_b,
                                   // [79:56] value_c
    output logic [5:0]  m_tuser,   // [0] record_valid, [4:1] kind, [5] frame_ok
    output logic        m_tlast    // frame_end
);

    logic             byte_en;
    logic             res_gen;
    lpp_pkg::result_t res;

    logic             out_valid_reg;
    lpp_pkg::result_t out_reg;
    logic             skid_valid_reg;
    lpp_pkg::result_t skid_reg;
    logic             pop;

    assign s_tready = !skid_valid_reg;
    assign byte_en  = s_tvalid && s_tready;

    lpp_parser #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (byte_en),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res_gen   (res_gen),
        .res       (res)
    );

    // output register can take a new word
    assign pop = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_gen;
            end
        end else if (res_gen) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        // hold the skid word until the output frees up
        if (!pop && res_gen) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.value_c, out_reg.value_b, out_reg.value_a, out_reg.channel};
    assign m_tuser  = {out_reg.frame_ok, out_reg.kind, out_reg.record_valid};
    assign m_tlast  = out_reg.frame_end;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while the output register is empty");

    a_result_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] || m_tlast))
        else $error("result word is neither a record nor a frame end");

    a_ok_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[5]) |-> m_tlast)
        else $error("frame_ok set outside frame end");

    a_empty_record_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 80'd0 && m_tuser[4:1] == 4'd0))
        else $error("payload not zero on a word without a record");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[4:1] <= lpp_pkg::KIND_GPS))
        else $error("record kind out of range");

endmodule
